// ===== hdl/heightgrid_vertex_normal_macros.svh =====
// assertion helpers for the checker file
`ifndef HEIGHTGRID_VERTEX_NORMAL_MACROS_SVH
`define HEIGHTGRID_VERTEX_NORMAL_MACROS_SVH

// property checked outside reset
`define HVN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked at every edge, reset included
`define HVN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/hvn_pkg.sv =====
`default_nettype none
package hvn_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EDGE_MUL,
        ST_EDGE_SQRT,
        ST_CORN_MUL,
        ST_CORN_DIV,
        ST_MAG_MUL,
        ST_MAG_SQRT,
        ST_OUT_DIV,
        ST_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_SQRT,
        ALU_DIVT,
        ALU_DIVO
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } alu_rsp_t;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int CFG_AW = 4;
    localparam logic [CFG_AW-1:0] CFG_WIDTH_IDX  = 4'd0;
    localparam logic [CFG_AW-1:0] CFG_LENGTH_IDX = 4'd1;

    // neighbor, corner and component codes
    localparam logic [1:0] NB_RIGHT  = 2'd0;
    localparam logic [1:0] NB_TOP    = 2'd1;
    localparam logic [1:0] NB_LEFT   = 2'd2;
    localparam logic [1:0] NB_BOTTOM = 2'd3;

    localparam logic [1:0] CN_TOP_RIGHT   = 2'd0;
    localparam logic [1:0] CN_LEFT_TOP    = 2'd1;
    localparam logic [1:0] CN_BOTTOM_LEFT = 2'd2;
    localparam logic [1:0] CN_RIGHT_BOTTOM = 2'd3;

    localparam logic [1:0] CP_X = 2'd0;
    localparam logic [1:0] CP_Y = 2'd1;
    localparam logic [1:0] CP_Z = 2'd2;

    localparam int SQRT_STEPS = 32;
    localparam int DIVT_STEPS = 25;
    localparam int DIVO_STEPS = 16;
    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

    localparam logic [15:0] Y_UNIT   = 16'd256;
    localparam logic [14:0] Q_SAT    = 15'd16384;
    localparam logic [31:0] EDGE_ONE = 32'd65536;

endpackage
`default_nettype wire

// ===== hdl/hvn_mem.sv =====
`default_nettype none
module hvn_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/hvn_alu.sv =====
`default_nettype none
module hvn_alu import hvn_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic        busy_reg, busy_next;
    alu_op_t     op_reg, op_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] z_reg, z_next;
    logic [63:0] b_reg, b_next;

    logic [63:0] prod;
    logic [63:0] sq_sum;
    logic [63:0] sq_diff;
    logic        sq_ge;
    logic [64:0] dv_t;
    logic [64:0] dv_diff;
    logic        dv_ge;

    assign prod = req.a[31:0] * req.b[31:0];

    always_comb begin
        sq_sum  = y_reg + z_reg;
        sq_ge   = (x_reg >= sq_sum);
        sq_diff = x_reg - sq_sum;
        dv_t    = {x_reg, y_reg[63]};
        dv_ge   = (dv_t >= {1'b0, b_reg});
        dv_diff = dv_t - {1'b0, b_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        b_next    = b_reg;
        if (!busy_reg) begin
            if (req.start) begin
                busy_next = 1'b1;
                op_next   = req.op;
                b_next    = req.b;
                unique case (req.op)
                    ALU_MUL: begin
                        z_next   = prod;
                        cnt_next = '0;
                    end
                    ALU_SQRT: begin
                        x_next   = req.a;
                        y_next   = '0;
                        z_next   = SQRT_BIT0;
                        cnt_next = 6'(SQRT_STEPS);
                    end
                    ALU_DIVT: begin
                        x_next   = req.a >> DIVT_STEPS;
                        y_next   = req.a << (64 - DIVT_STEPS);
                        z_next   = '0;
                        cnt_next = 6'(DIVT_STEPS);
                    end
                    ALU_DIVO: begin
                        x_next   = req.a >> DIVO_STEPS;
                        y_next   = req.a << (64 - DIVO_STEPS);
                        z_next   = '0;
                        cnt_next = 6'(DIVO_STEPS);
                    end
                endcase
            end
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 6'd1;
            if (op_reg == ALU_SQRT) begin
                // one result bit per step, trial bit moves down two places
                if (sq_ge) begin
                    x_next = sq_diff;
                    y_next = (y_reg >> 1) + z_reg;
                end else begin
                    y_next = y_reg >> 1;
                end
                z_next = z_reg >> 2;
            end else begin
                // restoring division, one quotient bit per step
                if (dv_ge) begin
                    x_next = dv_diff[63:0];
                    z_next = {z_reg[62:0], 1'b1};
                end else begin
                    x_next = dv_t[63:0];
                    z_next = {z_reg[62:0], 1'b0};
                end
                y_next = {y_reg[62:0], 1'b0};
            end
        end else begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        op_reg <= op_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        z_reg  <= z_next;
        b_reg  <= b_next;
    end

    always_comb begin
        rsp.done   = busy_reg && (cnt_reg == '0);
        rsp.result = (op_reg == ALU_SQRT) ? y_reg : z_reg;
    end

endmodule
`default_nettype wire

// ===== hdl/heightgrid_vertex_normal.sv =====
`default_nettype none
// Height grid with per-vertex normal queries.
// s_ channel: one beat is a command. s_tuser[0] = 0 loads s_tdata height at
// (col,row), 1 asks for the unit normal at (col,row). A load gives no
// result; a load outside the GRID_W x GRID_L grid is dropped.
// A query outside the grid in use gives no result either.
// m_ channel: one beat per answered query with the Q1.14 normal.
// cfg channel: writes the columns and rows in use (index 0 and 1), always
// ready. The user must write it while the block is idle; the block does not check this.
// A query reads five heights from the grid memory, then runs every multiply,
// square root and division through one shared iterative unit. Edge and
// corner vertices finish sooner, as the steps for missing neighbours and
// corners are skipped. s_tready is low while a query is worked on.
// The finished normal sits in an output register, so while the receiver
// stalls, loads and the next query are still taken; a second result waits
// until the first beat is taken.
// Reset clears the control state and sets both sizes to 256; the height
// grid is not cleared and must be loaded before it is queried.
module heightgrid_vertex_normal import hvn_pkg::*; #(
    parameter int GRID_W = 256,
    parameter int GRID_L = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // col[7:0], row[15:8], height[31:16]
    input  wire logic [0:0]        s_tuser,   // cmd[0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [47:0]       m_tdata,   // normal_x[15:0], normal_y[30:16],
                                              // normal_z[46:31], zero[47]
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [8:0]        cfg_wdata
);

    localparam int DEPTH = GRID_W * GRID_L;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [31:0]   GW32 = GRID_W;
    localparam logic [31:0]   GL32 = GRID_L;
    localparam logic [AW-1:0] GW_A = AW'(GRID_W);

    function automatic logic [15:0] abs17(input logic [16:0] d);
        logic [16:0] n;
        n = ~d + 17'd1;
        return d[16] ? n[15:0] : d[15:0];
    endfunction

    function automatic logic [26:0] abs28(input logic [27:0] s);
        logic [27:0] n;
        n = ~s + 28'd1;
        return s[27] ? n[26:0] : s[26:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [7:0] r, input logic [7:0] c);
        return AW'(r) * GW_A + AW'(c);
    endfunction

    seq_state_t state_reg, state_next;

    logic [8:0] width_cfg_reg, length_cfg_reg;
    logic [8:0] eff_w, eff_l;

    logic        in_cmd;
    logic [7:0]  in_col, in_row;
    logic [15:0] in_height;
    logic        s_accept, query_ok, load_ok;

    logic [7:0] col_reg, col_next, row_reg, row_next;
    logic has_r_reg, has_r_next, has_t_reg, has_t_next;
    logic has_l_reg, has_l_next, has_b_reg, has_b_next;
    logic [2:0] rk_reg, rk_next;
    logic [1:0] nb_reg, nb_next, cn_reg, cn_next, cp_reg, cp_next;
    logic       issued_reg, issued_next;
    logic [15:0] h_c_reg, h_c_next, h_r_reg, h_r_next, h_t_reg, h_t_next;
    logic [15:0] h_l_reg, h_l_next, h_b_reg, h_b_next;
    logic [24:0] len_r_reg, len_r_next, len_t_reg, len_t_next;
    logic [24:0] len_l_reg, len_l_next, len_b_reg, len_b_next;
    logic [31:0] tmp_reg, tmp_next;
    logic [49:0] den_reg, den_next;
    logic [27:0] sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    logic [54:0] qacc_reg, qacc_next;
    logic [31:0] mag_reg, mag_next;
    logic [15:0] ox_reg, ox_next, oz_reg, oz_next;
    logic [14:0] oy_reg, oy_next;
    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_rdata;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic [16:0] d_r, d_t, d_l, d_b;
    logic        nb_present, cn_present, op_done;
    logic [15:0] nb_mag;
    logic [24:0] len_a, len_b;
    logic        num_neg;
    logic [15:0] num_mag;
    logic [27:0] s_sel;
    logic [26:0] s_mag;
    logic [27:0] s_upd;
    logic [24:0] term_q;
    logic [14:0] out_sat;
    logic [15:0] out_signed;

    hvn_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_height),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hvn_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    // input fields and size clamping
    always_comb begin
        in_cmd    = s_tuser[0];
        in_col    = s_tdata[7:0];
        in_row    = s_tdata[15:8];
        in_height = s_tdata[31:16];

        if (width_cfg_reg < 9'd2) begin
            eff_w = 9'd2;
        end else if ({23'd0, width_cfg_reg} > GW32) begin
            eff_w = GW32[8:0];
        end else begin
            eff_w = width_cfg_reg;
        end
        if (length_cfg_reg < 9'd2) begin
            eff_l = 9'd2;
        end else if ({23'd0, length_cfg_reg} > GL32) begin
            eff_l = GL32[8:0];
        end else begin
            eff_l = length_cfg_reg;
        end

        query_ok = ({1'b0, in_col} < eff_w) && ({1'b0, in_row} < eff_l);
        load_ok  = ({24'd0, in_col} < GW32) && ({24'd0, in_row} < GL32);
    end

    // datapath selections
    always_comb begin
        d_r = {h_r_reg[15], h_r_reg} - {h_c_reg[15], h_c_reg};
        d_t = {h_t_reg[15], h_t_reg} - {h_c_reg[15], h_c_reg};
        d_l = {h_l_reg[15], h_l_reg} - {h_c_reg[15], h_c_reg};
        d_b = {h_b_reg[15], h_b_reg} - {h_c_reg[15], h_c_reg};
        op_done = issued_reg && alu_rsp.done;

        unique case (nb_reg)
            NB_RIGHT: begin
                nb_present = has_r_reg;
                nb_mag     = abs17(d_r);
            end
            NB_TOP: begin
                nb_present = has_t_reg;
                nb_mag     = abs17(d_t);
            end
            NB_LEFT: begin
                nb_present = has_l_reg;
                nb_mag     = abs17(d_l);
            end
            NB_BOTTOM: begin
                nb_present = has_b_reg;
                nb_mag     = abs17(d_b);
            end
        endcase

        unique case (cn_reg)
            CN_TOP_RIGHT: begin
                cn_present = has_t_reg && has_r_reg;
                len_a      = len_t_reg;
                len_b      = len_r_reg;
            end
            CN_LEFT_TOP: begin
                cn_present = has_l_reg && has_t_reg;
                len_a      = len_l_reg;
                len_b      = len_t_reg;
            end
            CN_BOTTOM_LEFT: begin
                cn_present = has_b_reg && has_l_reg;
                len_a      = len_b_reg;
                len_b      = len_l_reg;
            end
            CN_RIGHT_BOTTOM: begin
                cn_present = has_r_reg && has_b_reg;
                len_a      = len_r_reg;
                len_b      = len_b_reg;
            end
        endcase

        // cross product component numerator: x is -dr or dl, z is -dt or db
        num_neg = 1'b0;
        num_mag = Y_UNIT;
        if (cp_reg == CP_X) begin
            if (cn_reg == CN_TOP_RIGHT || cn_reg == CN_RIGHT_BOTTOM) begin
                num_neg = !d_r[16] && (d_r != '0);
                num_mag = abs17(d_r);
            end else begin
                num_neg = d_l[16];
                num_mag = abs17(d_l);
            end
        end else if (cp_reg == CP_Z) begin
            if (cn_reg == CN_TOP_RIGHT || cn_reg == CN_LEFT_TOP) begin
                num_neg = !d_t[16] && (d_t != '0);
                num_mag = abs17(d_t);
            end else begin
                num_neg = d_b[16];
                num_mag = abs17(d_b);
            end
        end

        unique case (cp_reg)
            CP_X:    s_sel = sx_reg;
            CP_Y:    s_sel = sy_reg;
            default: s_sel = sz_reg;
        endcase
        s_mag  = abs28(s_sel);
        term_q = alu_rsp.result[24:0];
        s_upd  = num_neg ? s_sel - {3'd0, term_q} : s_sel + {3'd0, term_q};

        if (mag_reg == '0) begin
            out_sat = '0;
        end else if (alu_rsp.result[15:0] > {1'b0, Q_SAT}) begin
            out_sat = Q_SAT;
        end else begin
            out_sat = alu_rsp.result[14:0];
        end
        out_signed = s_sel[27] ? (~{1'b0, out_sat} + 16'd1) : {1'b0, out_sat};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_cmd == CMD_QUERY && query_ok) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (rk_reg == 3'd5) begin
                    state_next = ST_EDGE_MUL;
                end
            end
            ST_EDGE_MUL: begin
                if (!nb_present) begin
                    state_next = (nb_reg == NB_BOTTOM) ? ST_CORN_MUL : ST_EDGE_MUL;
                end else if (op_done) begin
                    state_next = ST_EDGE_SQRT;
                end
            end
            ST_EDGE_SQRT: begin
                if (op_done) begin
                    state_next = (nb_reg == NB_BOTTOM) ? ST_CORN_MUL : ST_EDGE_MUL;
                end
            end
            ST_CORN_MUL: begin
                if (!cn_present) begin
                    state_next = (cn_reg == CN_RIGHT_BOTTOM) ? ST_MAG_MUL : ST_CORN_MUL;
                end else if (op_done) begin
                    state_next = ST_CORN_DIV;
                end
            end
            ST_CORN_DIV: begin
                if (op_done && cp_reg == CP_Z) begin
                    state_next = (cn_reg == CN_RIGHT_BOTTOM) ? ST_MAG_MUL : ST_CORN_MUL;
                end
            end
            ST_MAG_MUL: begin
                if (op_done && cp_reg == CP_Z) begin
                    state_next = ST_MAG_SQRT;
                end
            end
            ST_MAG_SQRT: begin
                if (op_done) begin
                    state_next = ST_OUT_DIV;
                end
            end
            ST_OUT_DIV: begin
                if (op_done && cp_reg == CP_Z) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        s_accept   = s_tvalid && s_tready;
        cfg_ready  = 1'b1;
        m_tvalid   = m_valid_reg;
        m_tdata    = m_data_reg;

        mem_we    = 1'b0;
        mem_waddr = addr_of(in_row, in_col);
        mem_raddr = addr_of(row_reg, col_reg);

        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;

        col_next    = col_reg;
        row_next    = row_reg;
        has_r_next  = has_r_reg;
        has_t_next  = has_t_reg;
        has_l_next  = has_l_reg;
        has_b_next  = has_b_reg;
        rk_next     = rk_reg;
        nb_next     = nb_reg;
        cn_next     = cn_reg;
        cp_next     = cp_reg;
        issued_next = issued_reg;
        h_c_next    = h_c_reg;
        h_r_next    = h_r_reg;
        h_t_next    = h_t_reg;
        h_l_next    = h_l_reg;
        h_b_next    = h_b_reg;
        len_r_next  = len_r_reg;
        len_t_next  = len_t_reg;
        len_l_next  = len_l_reg;
        len_b_next  = len_b_reg;
        tmp_next    = tmp_reg;
        den_next    = den_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sz_next     = sz_reg;
        qacc_next   = qacc_reg;
        mag_next    = mag_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oz_next     = oz_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (in_cmd == CMD_LOAD) begin
                        mem_we = load_ok;
                    end else begin
                        col_next    = in_col;
                        row_next    = in_row;
                        has_r_next  = (({1'b0, in_col}) + 9'd1) < eff_w;
                        has_t_next  = (({1'b0, in_row}) + 9'd1) < eff_l;
                        has_l_next  = (in_col != '0);
                        has_b_next  = (in_row != '0);
                        rk_next     = '0;
                        nb_next     = NB_RIGHT;
                        cn_next     = CN_TOP_RIGHT;
                        cp_next     = CP_X;
                        issued_next = 1'b0;
                        sx_next     = '0;
                        sy_next     = '0;
                        sz_next     = '0;
                        qacc_next   = '0;
                    end
                end
            end
            ST_READ: begin
                // read data arrives in the cycle after its address
                unique case (rk_reg)
                    3'd1: mem_raddr = has_r_reg ? addr_of(row_reg, col_reg + 8'd1) : mem_raddr;
                    3'd2: mem_raddr = has_t_reg ? addr_of(row_reg + 8'd1, col_reg) : mem_raddr;
                    3'd3: mem_raddr = has_l_reg ? addr_of(row_reg, col_reg - 8'd1) : mem_raddr;
                    3'd4: mem_raddr = has_b_reg ? addr_of(row_reg - 8'd1, col_reg) : mem_raddr;
                    default: mem_raddr = addr_of(row_reg, col_reg);
                endcase
                unique case (rk_reg)
                    3'd1:    h_c_next = mem_rdata;
                    3'd2:    h_r_next = mem_rdata;
                    3'd3:    h_t_next = mem_rdata;
                    3'd4:    h_l_next = mem_rdata;
                    3'd5:    h_b_next = mem_rdata;
                    default: h_c_next = h_c_reg;
                endcase
                rk_next = rk_reg + 3'd1;
            end
            ST_EDGE_MUL: begin
                if (!nb_present) begin
                    nb_next = nb_reg + 2'd1;
                end else begin
                    alu_req.op = ALU_MUL;
                    alu_req.a  = {48'd0, nb_mag};
                    alu_req.b  = {48'd0, nb_mag};
                    if (!issued_reg) begin
                        alu_req.start = 1'b1;
                        issued_next   = 1'b1;
                    end
                    if (op_done) begin
                        tmp_next    = alu_rsp.result[31:0];
                        issued_next = 1'b0;
                    end
                end
            end
            ST_EDGE_SQRT: begin
                alu_req.op = ALU_SQRT;
                alu_req.a  = {16'd0, tmp_reg + EDGE_ONE, 16'd0};
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end
                if (op_done) begin
                    issued_next = 1'b0;
                    nb_next     = nb_reg + 2'd1;
                    unique case (nb_reg)
                        NB_RIGHT:  len_r_next = alu_rsp.result[24:0];
                        NB_TOP:    len_t_next = alu_rsp.result[24:0];
                        NB_LEFT:   len_l_next = alu_rsp.result[24:0];
                        NB_BOTTOM: len_b_next = alu_rsp.result[24:0];
                    endcase
                end
            end
            ST_CORN_MUL: begin
                if (!cn_present) begin
                    cn_next = cn_reg + 2'd1;
                end else begin
                    alu_req.op = ALU_MUL;
                    alu_req.a  = {39'd0, len_a};
                    alu_req.b  = {39'd0, len_b};
                    if (!issued_reg) begin
                        alu_req.start = 1'b1;
                        issued_next   = 1'b1;
                    end
                    if (op_done) begin
                        den_next    = alu_rsp.result[49:0];
                        issued_next = 1'b0;
                    end
                end
            end
            ST_CORN_DIV: begin
                alu_req.op = ALU_DIVT;
                alu_req.a  = {num_mag, 48'd0};
                alu_req.b  = {14'd0, den_reg};
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end
                if (op_done) begin
                    issued_next = 1'b0;
                    unique case (cp_reg)
                        CP_X:    sx_next = s_upd;
                        CP_Y:    sy_next = s_upd;
                        default: sz_next = s_upd;
                    endcase
                    if (cp_reg == CP_Z) begin
                        cp_next = CP_X;
                        cn_next = cn_reg + 2'd1;
                    end else begin
                        cp_next = cp_reg + 2'd1;
                    end
                end
            end
            ST_MAG_MUL: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = {37'd0, s_mag};
                alu_req.b  = {37'd0, s_mag};
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end
                if (op_done) begin
                    issued_next = 1'b0;
                    qacc_next   = qacc_reg + {1'b0, alu_rsp.result[53:0]};
                    cp_next     = (cp_reg == CP_Z) ? CP_X : cp_reg + 2'd1;
                end
            end
            ST_MAG_SQRT: begin
                alu_req.op = ALU_SQRT;
                alu_req.a  = {1'b0, qacc_reg, 8'd0};
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end
                if (op_done) begin
                    issued_next = 1'b0;
                    mag_next    = alu_rsp.result[31:0];
                end
            end
            ST_OUT_DIV: begin
                // rounded quotient: add half the divisor first
                alu_req.op = ALU_DIVO;
                alu_req.a  = {19'd0, s_mag, 18'd0} + {33'd0, mag_reg[31:1]};
                alu_req.b  = {32'd0, mag_reg};
                if (!issued_reg) begin
                    alu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end
                if (op_done) begin
                    issued_next = 1'b0;
                    unique case (cp_reg)
                        CP_X:    ox_next = out_signed;
                        CP_Y:    oy_next = out_sat;
                        default: oz_next = out_signed;
                    endcase
                    cp_next = (cp_reg == CP_Z) ? CP_X : cp_reg + 2'd1;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, oz_reg, oy_reg, ox_reg};
                end
            end
            default: begin
                issued_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            width_cfg_reg  <= 9'd256;
            length_cfg_reg <= 9'd256;
            issued_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == CFG_WIDTH_IDX) begin
                    width_cfg_reg <= cfg_wdata;
                end else if (cfg_addr == CFG_LENGTH_IDX) begin
                    length_cfg_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        has_r_reg  <= has_r_next;
        has_t_reg  <= has_t_next;
        has_l_reg  <= has_l_next;
        has_b_reg  <= has_b_next;
        rk_reg     <= rk_next;
        nb_reg     <= nb_next;
        cn_reg     <= cn_next;
        cp_reg     <= cp_next;
        h_c_reg    <= h_c_next;
        h_r_reg    <= h_r_next;
        h_t_reg    <= h_t_next;
        h_l_reg    <= h_l_next;
        h_b_reg    <= h_b_next;
        len_r_reg  <= len_r_next;
        len_t_reg  <= len_t_next;
        len_l_reg  <= len_l_next;
        len_b_reg  <= len_b_next;
        tmp_reg    <= tmp_next;
        den_reg    <= den_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        sz_reg     <= sz_next;
        qacc_reg   <= qacc_next;
        mag_reg    <= mag_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

// ===== hdl/hvn_check.sv =====
`default_nettype none
`include "heightgrid_vertex_normal_macros.svh"
module hvn_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    `HVN_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result beat right after reset")

    `HVN_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled beat changed")

    `HVN_ASSERT(a_load_silent, s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid, "load made a result")

    `HVN_ASSERT(a_y_range, m_tvalid |-> m_tdata[30:16] <= 15'd16384 && !m_tdata[47], "normal y out of range")

endmodule

bind heightgrid_vertex_normal hvn_check u_hvn_check (.*);
`default_nettype wire
